// File: src/bfdh_pkg.sv
package bfdh_pkg;

	localparam int MAX_LOG2_BITS_DEF = 16;
	localparam int WORD_W = 64;
	localparam int HALF_W = 32;
	localparam int WORD_BITS_LOG2 = 6;

	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_INDEX_W-1:0] REG_LOG2_BITS = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PROBE_COUNT = 4'd1;

	localparam logic [4:0] LOG2_BITS_RST = 5'd16;
	localparam logic [6:0] PROBE_COUNT_RST = 7'd7;
	localparam logic [6:0] PROBE_LIMIT = 7'd64;

	localparam logic [63:0] FNV_SEED = 64'hcbf29ce484222325;
	localparam logic [63:0] MIX_SEED = 64'h9e3779b97f4a7c15;
	// FNV prime is 2^40 + 0x1b3
	localparam logic [8:0] FNV_PRIME_LO = 9'h1b3;
	localparam int FNV_PRIME_SHIFT = 40;

	localparam logic [63:0] FIN_C0 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] FIN_C1 = 64'hc4ceb9fe1a85ec53;
	localparam logic [63:0] FIN_C2 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] FIN_C3 = 64'h94d049bb133111eb;

	function automatic logic [63:0] fin_const(input logic [1:0] sel);
		logic [63:0] c;
		case (sel)
			2'd0: c = FIN_C0;
			2'd1: c = FIN_C1;
			2'd2: c = FIN_C2;
			default: c = FIN_C3;
		endcase
		return c;
	endfunction

endpackage

// File: src/bfdh_mul64.sv
// Low 64 bits of a 64x64 product, one 32x32 partial product per cycle.
module bfdh_mul64 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] op_a,
	input  logic [63:0] op_b,
	output logic        done,
	output logic [63:0] prod
);

	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] acc_q;
	logic [63:0] prod_s1;
	logic [1:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [bfdh_pkg::HALF_W-1:0] op_x;
	logic [bfdh_pkg::HALF_W-1:0] op_y;

	// step 0: aL*bL, step 1: aL*bH, step 2: aH*bL
	assign op_x = (step_q == 2'd2) ? a_q[63:32] : a_q[31:0];
	assign op_y = (step_q == 2'd1) ? b_q[63:32] : b_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= op_a;
			b_q <= op_b;
		end else if (busy_q) begin
			prod_s1 <= 64'(op_x) * 64'(op_y);
			case (step_q)
				2'd0: acc_q <= acc_q;
				2'd1: acc_q <= prod_s1;
				default: acc_q <= acc_q + {prod_s1[31:0], 32'd0};
			endcase
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// File: src/bloom_filter_double_hash_core.sv
// Bloom filter with double hashing, fed one key byte per transfer.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tdata: key_byte; tuser: kind, has_byte;
//          |     |                    | tlast: last_byte
//  m_*     | out | m_tvalid/m_tready  | tdata[0]: maybe_present (query only)
//  cfg_*   | in  | cfg_we             | cfg_index, cfg_data
//
// A byte that does not end a key is absorbed in the cycle of its transfer, so such
// bytes stream at one per cycle. A key end runs four 64x64 finalize multiplies on the
// shared iterative multiplier, then a read of the bit store per probe (the clamped
// probe count), with a write-back of that word on an add. After reset the bit store
// is swept to zero, one word per cycle, over all 2^(MAX_LOG2_BITS-6) words; s_tready
// stays low until the sweep ends. A pending query result holds in the output register;
// byte transfers go on meanwhile, until a later query result has to wait for it.
module bloom_filter_double_hash_core #(
	parameter int MAX_LOG2_BITS = bfdh_pkg::MAX_LOG2_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] key_byte
	input  logic [1:0]  s_tuser,   // [0] kind, [1] has_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] maybe_present, [7:1] zero
	input  logic        cfg_we,
	input  logic [bfdh_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bfdh_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int WORDS = 1 << (MAX_LOG2_BITS - bfdh_pkg::WORD_BITS_LOG2);
	localparam int AW = (MAX_LOG2_BITS > bfdh_pkg::WORD_BITS_LOG2) ?
		MAX_LOG2_BITS - bfdh_pkg::WORD_BITS_LOG2 : 1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_PRE,
		S_PRE2,
		S_MSTART,
		S_MWAIT,
		S_PSETUP,
		S_PRD,
		S_PWR,
		S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [4:0] log2_q;
	logic [6:0] probe_q;

	// hash accumulators and finalize working registers
	logic [63:0] fnv_q;
	logic [63:0] mix_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic        kind_q;
	logic [1:0]  m_q;

	// probe walk
	logic [MAX_LOG2_BITS-1:0] pos_q;
	logic [MAX_LOG2_BITS-1:0] step_q;
	logic [MAX_LOG2_BITS-1:0] mask_q;
	logic [6:0] cnt_q;
	logic       all_q;
	logic [AW-1:0] clr_q;

	// result register
	logic res_valid_q;
	logic res_q;
	logic res_load;

	// bit store
	logic [63:0] mem [WORDS];
	logic [63:0] rd_q;
	logic        mem_we;
	logic [AW-1:0] mem_wa;
	logic [63:0] mem_wd;
	logic [AW-1:0] word_idx;

	logic [63:0] fnv_x;
	logic [63:0] fnv_next;
	logic [63:0] mix_1;
	logic [63:0] mix_2;
	logic [63:0] mix_next;
	logic [63:0] fnv_abs;
	logic [63:0] mix_abs;
	logic        s_xfer;
	logic        has_byte;
	logic [4:0]  lb;
	logic [MAX_LOG2_BITS:0]   one_sh;
	logic [MAX_LOG2_BITS-1:0] mask_c;
	logic [6:0]  k_c;
	logic [MAX_LOG2_BITS-1:0] pos_m;
	logic [5:0]  bit_idx;
	logic [63:0] bit_mask;

	logic        mul_start;
	logic [63:0] mul_a;
	logic        mul_done;
	logic [63:0] mul_p;

	assign s_tready = (state_q == S_IDLE);
	assign s_xfer = s_tvalid && s_tready;
	assign has_byte = s_tuser[1];

	// FNV-1a step: xor byte, multiply by 2^40 + 0x1b3
	assign fnv_x = fnv_q ^ 64'(s_tdata);
	assign fnv_next = (fnv_x << bfdh_pkg::FNV_PRIME_SHIFT) +
		64'(fnv_x * 64'(bfdh_pkg::FNV_PRIME_LO));
	// shift-add mix step
	assign mix_1 = mix_q + 64'(s_tdata);
	assign mix_2 = mix_1 + (mix_1 << 10);
	assign mix_next = mix_2 ^ (mix_2 >> 6);

	assign fnv_abs = has_byte ? fnv_next : fnv_q;
	assign mix_abs = has_byte ? mix_next : mix_q;

	// clamp size and probe count
	assign lb = (log2_q > 5'(MAX_LOG2_BITS)) ? 5'(MAX_LOG2_BITS) : log2_q;
	assign one_sh = (MAX_LOG2_BITS + 1)'(1) << lb;
	assign mask_c = MAX_LOG2_BITS'(one_sh - (MAX_LOG2_BITS + 1)'(1));
	assign k_c = (probe_q > bfdh_pkg::PROBE_LIMIT) ? bfdh_pkg::PROBE_LIMIT : probe_q;

	assign pos_m = pos_q & mask_q;
	assign word_idx = AW'(pos_m >> bfdh_pkg::WORD_BITS_LOG2);
	assign bit_idx = pos_m[5:0];
	assign bit_mask = 64'd1 << bit_idx;

	// load the result register when it is empty or drains in this cycle
	assign res_load = (state_q == S_OUT) && (!res_valid_q || m_tready);

	// finalize multiplier: fnv side first, then the mix side
	assign mul_start = (state_q == S_MSTART);
	assign mul_a = m_q[1] ? b_q : a_q;

	bfdh_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.op_a   (mul_a),
		.op_b   (bfdh_pkg::fin_const(m_q)),
		.done   (mul_done),
		.prod   (mul_p)
	);

	// one write port: clearing sweep or probe write-back of an add
	always_comb begin
		mem_we = 1'b0;
		mem_wa = word_idx;
		mem_wd = rd_q | bit_mask;
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = 64'd0;
		end else if (state_q == S_PWR && !kind_q) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_q <= mem[word_idx];
	end

	// configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_q <= bfdh_pkg::LOG2_BITS_RST;
			probe_q <= bfdh_pkg::PROBE_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bfdh_pkg::REG_LOG2_BITS: log2_q <= cfg_data[4:0];
				bfdh_pkg::REG_PROBE_COUNT: probe_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			fnv_q <= bfdh_pkg::FNV_SEED;
			mix_q <= bfdh_pkg::MIX_SEED;
			a_q <= '0;
			b_q <= '0;
			kind_q <= 1'b0;
			pos_q <= '0;
			step_q <= '0;
			mask_q <= '0;
			all_q <= 1'b0;
			res_valid_q <= 1'b0;
			res_q <= 1'b0;
			m_q <= 2'd0;
			cnt_q <= 7'd0;
		end else begin
			if (m_tvalid && m_tready && !res_load)
				res_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(WORDS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_xfer) begin
						if (s_tlast) begin
							// hand the absorbed key to finalize, restart the accumulators
							a_q <= fnv_abs;
							b_q <= mix_abs;
							kind_q <= s_tuser[0];
							fnv_q <= bfdh_pkg::FNV_SEED;
							mix_q <= bfdh_pkg::MIX_SEED;
							state_q <= S_PRE;
						end else begin
							fnv_q <= fnv_abs;
							mix_q <= mix_abs;
						end
					end
				end
				S_PRE: begin
					a_q <= a_q ^ (a_q >> 33);
					b_q <= b_q + bfdh_pkg::MIX_SEED;
					state_q <= S_PRE2;
				end
				S_PRE2: begin
					b_q <= b_q ^ (b_q >> 30);
					m_q <= 2'd0;
					state_q <= S_MSTART;
				end
				S_MSTART: state_q <= S_MWAIT;
				S_MWAIT: begin
					if (mul_done) begin
						case (m_q)
							2'd0, 2'd1: a_q <= mul_p ^ (mul_p >> 33);
							2'd2: b_q <= mul_p ^ (mul_p >> 27);
							default: b_q <= mul_p ^ (mul_p >> 31);
						endcase
						m_q <= m_q + 2'd1;
						state_q <= (m_q == 2'd3) ? S_PSETUP : S_MSTART;
					end
				end
				S_PSETUP: begin
					// h1 starts the walk, odd h2 is the stride
					pos_q <= a_q[MAX_LOG2_BITS-1:0];
					step_q <= b_q[MAX_LOG2_BITS-1:0] | MAX_LOG2_BITS'(1);
					mask_q <= mask_c;
					cnt_q <= k_c;
					all_q <= 1'b1;
					if (k_c == 7'd0)
						state_q <= kind_q ? S_OUT : S_IDLE;
					else
						state_q <= S_PRD;
				end
				S_PRD: state_q <= S_PWR;
				S_PWR: begin
					// word is in rd_q; set bit on add, test it on query
					if (kind_q && !rd_q[bit_idx])
						all_q <= 1'b0;
					pos_q <= pos_q + step_q;
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1)
						state_q <= kind_q ? S_OUT : S_IDLE;
					else
						state_q <= S_PRD;
				end
				S_OUT: begin
					// hold until the result register is free
					if (res_load) begin
						res_valid_q <= 1'b1;
						res_q <= all_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata = {7'd0, res_q};

endmodule

// File: test/bfdh_checker.sv
`timescale 1ns / 1ps
package bfdh_tb_pkg;

	typedef enum logic {
		OP_ADD   = 1'b0,
		OP_QUERY = 1'b1
	} op_e;

endpackage

module bfdh_checker #(
	parameter int MAX_LOG2_BITS = bfdh_pkg::MAX_LOG2_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        cfg_we,
	input  logic [bfdh_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bfdh_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int          fail_count,
	output int          answers_waiting,
	output int          answers_checked
);

	localparam int STORE_WORDS = 1 << (MAX_LOG2_BITS - bfdh_pkg::WORD_BITS_LOG2);
	localparam logic [63:0] FNV_MULT = 64'h00000100000001b3;

	logic [63:0] fnv_acc;
	logic [63:0] mix_acc;
	logic [63:0] filter_words [STORE_WORDS];
	logic [4:0]  log2_reg;
	logic [6:0]  probe_reg;
	logic        answer_q [$];
	logic        expected_bit;
	int          fails = 0;
	int          checked = 0;

	function automatic logic [63:0] fnv_absorb(input logic [63:0] acc, input logic [7:0] b);
		return (acc ^ {56'd0, b}) * FNV_MULT;
	endfunction

	function automatic logic [63:0] mix_absorb(input logic [63:0] acc, input logic [7:0] b);
		logic [63:0] m;
		m = acc + {56'd0, b};
		m = m + (m << 10);
		return m ^ (m >> 6);
	endfunction

	function automatic logic [63:0] fnv_avalanche(input logic [63:0] a);
		a = a ^ (a >> 33);
		a = a * bfdh_pkg::FIN_C0;
		a = a ^ (a >> 33);
		a = a * bfdh_pkg::FIN_C1;
		return a ^ (a >> 33);
	endfunction

	// second hash is forced odd so the probe stride never collapses
	function automatic logic [63:0] mix_avalanche(input logic [63:0] b);
		b = b + bfdh_pkg::MIX_SEED;
		b = (b ^ (b >> 30)) * bfdh_pkg::FIN_C2;
		b = (b ^ (b >> 27)) * bfdh_pkg::FIN_C3;
		b = b ^ (b >> 31);
		return b | 64'd1;
	endfunction

	task automatic report(input string what);
		fails++;
		$display("%0t ns mismatch: %s", $time, what);
	endtask

	// Finalize the key, then set or test every probe position.
	task automatic end_key(input bfdh_tb_pkg::op_e op);
		logic [63:0] h1;
		logic [63:0] h2;
		logic [63:0] mask;
		logic [63:0] pos;
		logic [63:0] idx;
		int          lb;
		int          k;
		int          w;
		logic        all_set;
		h1 = fnv_avalanche(fnv_acc);
		h2 = mix_avalanche(mix_acc);
		fnv_acc = bfdh_pkg::FNV_SEED;
		mix_acc = bfdh_pkg::MIX_SEED;
		lb = (log2_reg > MAX_LOG2_BITS) ? MAX_LOG2_BITS : int'(log2_reg);
		k = (probe_reg > bfdh_pkg::PROBE_LIMIT) ? int'(bfdh_pkg::PROBE_LIMIT) :
			int'(probe_reg);
		mask = (64'd1 << lb) - 64'd1;
		all_set = 1'b1;
		for (idx = 0; idx < k; idx++) begin
			pos = (h1 + idx * h2) & mask;
			w = int'(pos >> bfdh_pkg::WORD_BITS_LOG2);
			if (op == bfdh_tb_pkg::OP_ADD)
				filter_words[w][pos[5:0]] = 1'b1;
			else if (!filter_words[w][pos[5:0]])
				all_set = 1'b0;
		end
		if (op == bfdh_tb_pkg::OP_QUERY)
			answer_q.push_back(all_set);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fnv_acc = bfdh_pkg::FNV_SEED;
			mix_acc = bfdh_pkg::MIX_SEED;
			for (int w = 0; w < STORE_WORDS; w++)
				filter_words[w] = '0;
			log2_reg = bfdh_pkg::LOG2_BITS_RST;
			probe_reg = bfdh_pkg::PROBE_COUNT_RST;
			answer_q.delete();
		end else begin
			// retire the answer first: a new query cannot answer on its own edge
			if (m_tvalid && m_tready) begin
				if (answer_q.size() == 0) begin
					report($sformatf("answer %0d with no query pending", m_tdata[0]));
				end else begin
					expected_bit = answer_q.pop_front();
					checked++;
					if (m_tdata[0] !== expected_bit)
						report($sformatf("maybe_present %b, predicted %b",
							m_tdata[0], expected_bit));
					if (m_tdata[7:1] !== 7'd0)
						report($sformatf("padding bits %b not zero", m_tdata[7:1]));
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[1]) begin
					fnv_acc = fnv_absorb(fnv_acc, s_tdata);
					mix_acc = mix_absorb(mix_acc, s_tdata);
				end
				if (s_tlast)
					end_key(bfdh_tb_pkg::op_e'(s_tuser[0]));
			end
			if (cfg_we) begin
				case (cfg_index)
					bfdh_pkg::REG_LOG2_BITS: log2_reg = cfg_data[4:0];
					bfdh_pkg::REG_PROBE_COUNT: probe_reg = cfg_data;
					default: ;
				endcase
			end
		end
		fail_count <= fails;
		answers_waiting <= answer_q.size();
		answers_checked <= checked;
	end

endmodule

// File: test/bloom_filter_double_hash_core_tb.sv
`timescale 1ns / 1ps
module bloom_filter_double_hash_core_tb;

	localparam int ITEM_TARGET   = 1550;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 200;
	localparam int LONG_HOLD     = 600;
	localparam int KEY_MAX       = 24;
	localparam int RECENT_MAX    = 40;
	localparam int N_SETTINGS    = 8;
	localparam int HOLD_PHASE    = 6;
	localparam logic [bfdh_pkg::CFG_INDEX_W-1:0] REG_SPARE = 4'hf;

	// Filter settings per phase, phase 0 in the lowest slot. The list covers a single
	// filter bit, the full size, sizes above the limit (116 and 31 keep 20 and 31 in
	// five bits), zero probes, 64 probes and probe counts past the limit.
	localparam logic [N_SETTINGS-1:0][6:0] LOG2_PLAN =
		{7'd12, 7'd6, 7'd10, 7'd31, 7'd4, 7'd116, 7'd16, 7'd0};
	localparam logic [N_SETTINGS-1:0][6:0] PROBE_PLAN =
		{7'd2, 7'd100, 7'd7, 7'd3, 7'd127, 7'd0, 7'd64, 7'd1};

	typedef struct packed {
		logic [KEY_MAX-1:0][7:0] b;
		logic [5:0]              len;
	} key_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] key_byte
	logic [1:0]  s_tuser;   // [0] kind, [1] has_byte
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;   // [0] maybe_present, [7:1] zero
	logic        cfg_we;
	logic [bfdh_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [bfdh_pkg::CFG_DATA_W-1:0]  cfg_data;

	int   fail_count;
	int   answers_waiting;
	int   answers_checked;

	int   tx_idle_pct = 7;
	int   rx_idle_pct = 52;
	int   items_sent = 0;
	int   n_adds = 0;
	int   n_queries = 0;
	int   cycles = 0;
	logic hold_go;
	logic hold_used = 1'b0;
	int   hold_left = 0;
	key_t recent_keys [$];

	always #1 clk = ~clk;

	bloom_filter_double_hash_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bfdh_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.answers_waiting (answers_waiting),
		.answers_checked (answers_checked)
	);

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: stall at random, and once hold off for a long stretch so the output
	// register fills and the block has to stall its input.
	always @(posedge clk) begin
		if (hold_go && !hold_used) begin
			hold_used <= 1'b1;
			hold_left <= LONG_HOLD;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Offer one item and hold it until its transfer. Idle cycles put noise on the bus.
	task automatic put_item(input logic kind, input logic [7:0] b, input logic has,
			input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'($urandom_range(255));
			s_tuser <= 2'($urandom_range(3));
			s_tlast <= 1'($urandom_range(1));
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= {has, kind};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		if (last) begin
			if (kind == bfdh_tb_pkg::OP_QUERY)
				n_queries++;
			else
				n_adds++;
		end
		// idle profile: sender light and receiver heavy, then swapped, then none
		if (items_sent < ITEM_TARGET / 3) begin
			tx_idle_pct = 7;
			rx_idle_pct <= 52;
		end else if (items_sent < 2 * ITEM_TARGET / 3) begin
			tx_idle_pct = 52;
			rx_idle_pct <= 7;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct <= 0;
		end
	endtask

	// Send one key. Kind on the earlier items is junk; a key may end on a byte or on
	// an item with no byte, and stray no-byte items may fall between its bytes.
	task automatic send_key(input bfdh_tb_pkg::op_e op, input key_t k,
			input logic tail_empty);
		int   j;
		logic ends_here;
		for (j = 0; j < k.len; j++) begin
			if ($urandom_range(99) < 8)
				put_item(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, 1'b0);
			ends_here = (j == k.len - 1) && !tail_empty;
			put_item(ends_here ? op : 1'($urandom_range(1)), k.b[j], 1'b1, ends_here);
		end
		if (k.len == 0 || tail_empty)
			put_item(op, 8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	// Random keys until the item count reaches the goal. Queries often repeat a key
	// that was added, so hits and misses both occur.
	task automatic run_keys(input int goal);
		bfdh_tb_pkg::op_e op;
		key_t k;
		int   j;
		while (items_sent < goal) begin
			op = ($urandom_range(99) < 40) ? bfdh_tb_pkg::OP_ADD : bfdh_tb_pkg::OP_QUERY;
			if (recent_keys.size() != 0 &&
					$urandom_range(99) < ((op == bfdh_tb_pkg::OP_QUERY) ? 50 : 25)) begin
				k = recent_keys[$urandom_range(recent_keys.size() - 1)];
			end else begin
				k.len = ($urandom_range(15) == 0) ? 6'($urandom_range(KEY_MAX)) :
					6'($urandom_range(6));
				for (j = 0; j < KEY_MAX; j++) begin
					case ($urandom_range(7))
						0: k.b[j] = 8'h00;
						1: k.b[j] = 8'hff;
						default: k.b[j] = 8'($urandom_range(255));
					endcase
				end
			end
			send_key(op, k, 1'($urandom_range(1)));
			if (op == bfdh_tb_pkg::OP_ADD) begin
				recent_keys.push_back(k);
				if (recent_keys.size() > RECENT_MAX)
					void'(recent_keys.pop_front());
			end
		end
	endtask

	task automatic write_reg(input logic [bfdh_pkg::CFG_INDEX_W-1:0] index,
			input logic [bfdh_pkg::CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
	endtask

	// Write both registers plus one index that the block must ignore.
	task automatic set_filter(input logic [6:0] lb, input logic [6:0] pc);
		write_reg(bfdh_pkg::REG_LOG2_BITS, lb);
		write_reg(REG_SPARE, 7'($urandom_range(127)));
		write_reg(bfdh_pkg::REG_PROBE_COUNT, pc);
		cfg_we <= 1'b0;
	endtask

	// Drop valid, wait out every pending answer, then let a trailing add finish.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (answers_waiting != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int p;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'd0;
		s_tuser <= 2'd0;
		s_tlast <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		hold_go <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed keys at the reset settings. The store sweep holds off the first
		// transfer. Empty key: query before and after adding it.
		put_item(bfdh_tb_pkg::OP_QUERY, 8'h00, 1'b0, 1'b1);
		put_item(bfdh_tb_pkg::OP_ADD, 8'hff, 1'b0, 1'b1);
		put_item(bfdh_tb_pkg::OP_QUERY, 8'h5a, 1'b0, 1'b1);
		// byte extremes; kind on the first item must not matter
		put_item(bfdh_tb_pkg::OP_QUERY, 8'h00, 1'b1, 1'b0);
		put_item(bfdh_tb_pkg::OP_ADD, 8'hff, 1'b1, 1'b1);
		// same key ended by a no-byte item, then the bytes swapped
		put_item(bfdh_tb_pkg::OP_ADD, 8'h00, 1'b1, 1'b0);
		put_item(bfdh_tb_pkg::OP_ADD, 8'hff, 1'b1, 1'b0);
		put_item(bfdh_tb_pkg::OP_QUERY, 8'h77, 1'b0, 1'b1);
		put_item(bfdh_tb_pkg::OP_ADD, 8'hff, 1'b1, 1'b0);
		put_item(bfdh_tb_pkg::OP_QUERY, 8'h00, 1'b1, 1'b1);
		// no-byte item inside a key leaves the hashes alone
		put_item(bfdh_tb_pkg::OP_QUERY, 8'h55, 1'b1, 1'b0);
		put_item(bfdh_tb_pkg::OP_QUERY, 8'h3c, 1'b0, 1'b0);
		put_item(bfdh_tb_pkg::OP_ADD, 8'haa, 1'b1, 1'b1);
		put_item(bfdh_tb_pkg::OP_ADD, 8'h55, 1'b1, 1'b0);
		put_item(bfdh_tb_pkg::OP_ADD, 8'haa, 1'b1, 1'b0);
		put_item(bfdh_tb_pkg::OP_QUERY, 8'hc3, 1'b0, 1'b1);
		// single-byte keys
		put_item(bfdh_tb_pkg::OP_ADD, 8'h80, 1'b1, 1'b1);
		put_item(bfdh_tb_pkg::OP_QUERY, 8'h01, 1'b1, 1'b1);
		put_item(bfdh_tb_pkg::OP_QUERY, 8'h80, 1'b1, 1'b1);
		drain();

		for (p = 0; p < N_SETTINGS; p++) begin
			set_filter(LOG2_PLAN[p], PROBE_PLAN[p]);
			if (p == HOLD_PHASE)
				hold_go <= 1'b1;
			run_keys(ITEM_TARGET * (p + 1) / N_SETTINGS);
			drain();
		end

		$display("summary: %0d items, %0d adds, %0d queries, %0d answers checked",
			items_sent, n_adds, n_queries, answers_checked);
		$display("summary: reset settings plus %0d filter settings, one long output stall",
			N_SETTINGS);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
